// ===== hdl/wes_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wave equation stencil package
// Shared constants, types and codes for the wave equation stencil step.
// ----------------------------------------------------------------------------
package wes_pkg;

  localparam int MaxColumns = 1024;
  localparam int MaxRows    = 1024;
  localparam int ColW       = $clog2(MaxColumns);
  localparam int RowW       = $clog2(MaxRows);
  localparam int SizeW      = 11;
  localparam int ValW       = 32;
  localparam int MedW       = 24;
  localparam int CoefW      = 24;
  localparam int DiffW      = ValW + 1;
  localparam int SumW       = MedW + 1;
  localparam int ProdW      = DiffW + SumW + 1;
  localparam int TermW      = ProdW + 1;
  localparam int LoW        = 30;
  localparam int HiW        = TermW - LoW;
  localparam int PartLoW    = LoW + CoefW;
  localparam int PartHiW    = HiW + CoefW + 1;
  localparam int ScaledW    = TermW + CoefW + 3;
  localparam int TotalW     = ScaledW + 1;
  localparam int FracShift  = 44;
  localparam int DeltaW     = TotalW - FracShift;
  localparam int BaseW      = ValW + 2;
  localparam int ResW       = DeltaW + 1;

  typedef enum logic [1:0] {
    CfgCoefX       = 2'd0,
    CfgCoefY       = 2'd1,
    CfgGridColumns = 2'd2,
    CfgGridRows    = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    SeqIdle  = 2'd0,
    SeqRead  = 2'd1,
    SeqWrite = 2'd2
  } seq_state_e;

  typedef struct packed {
    logic [ValW-1:0] u_now;
    logic [ValW-1:0] u_before;
    logic [MedW-1:0] med;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic            interior;
    logic            last;
  } item_t;

  typedef struct packed {
    logic [CoefW-1:0] coef_x;
    logic [CoefW-1:0] coef_y;
  } coef_t;

  typedef struct packed {
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic            last;
  } tag_t;

endpackage

// ===== hdl/wes_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wave equation stencil front end
// Tracks the raster position of incoming items and classifies each point.
// ----------------------------------------------------------------------------
module wes_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [wes_pkg::SizeW-1:0] cols_i,
  input  logic [wes_pkg::SizeW-1:0] rows_i,
  input  logic                 accept_i,
  input  logic [wes_pkg::ValW-1:0] u_now_i,
  input  logic [wes_pkg::ValW-1:0] u_before_i,
  input  logic [wes_pkg::MedW-1:0] medium_req_i,
  input  logic                 frame_start_i,
  output wes_pkg::item_t       item_o
);
  import wes_pkg::*;

  logic [ColW-1:0]  col_q, col_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [SizeW-1:0] c0, c1, r0, r1, r2, cn, rn;

  always_comb begin
    c0 = frame_start_i ? '0 : {1'b0, col_q};
    r0 = frame_start_i ? '0 : {1'b0, row_q};
    if (c0 >= cols_i) begin
      c1 = '0;
      r1 = r0 + 11'd1;
    end else begin
      c1 = c0;
      r1 = r0;
    end
    r2 = (r1 >= rows_i) ? '0 : r1;
    cn = c1 + 11'd1;
    rn = r2 + 11'd1;
    if (cn >= cols_i) begin
      col_d = '0;
      row_d = (rn >= rows_i) ? '0 : rn[RowW-1:0];
    end else begin
      col_d = cn[ColW-1:0];
      row_d = r2[RowW-1:0];
    end
  end

  always_comb begin
    item_o.u_now    = u_now_i;
    item_o.u_before = u_before_i;
    item_o.med      = medium_req_i;
    item_o.row      = r2[RowW-1:0] - 1'b1;
    item_o.col      = c1[ColW-1:0];
    item_o.interior = (r2 >= 11'd2) && (c1 >= 11'd1) && (c1 + 11'd2 <= cols_i);
    item_o.last     = (r2 == rows_i - 11'd1) && (c1 == cols_i - 11'd2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

// ===== hdl/wes_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wave equation stencil item queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module wes_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  wes_pkg::item_t push_item_i,
  input  logic           pop_i,
  output wes_pkg::item_t pop_item_o,
  output logic           full_o,
  output logic           empty_o
);
  import wes_pkg::*;

  item_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o     = (count_q == 2'd2);
  assign empty_o    = (count_q == 2'd0);
  assign pop_item_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== hdl/wes_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wave equation stencil back end
// Line buffers, stencil arithmetic pipeline and output register.
// ----------------------------------------------------------------------------
module wes_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  wes_pkg::coef_t        coef_i,
  input  wes_pkg::item_t        item_i,
  input  logic                  item_avail_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [wes_pkg::ValW-1:0] u_next_o,
  output logic [wes_pkg::RowW-1:0] row_index_o,
  output logic [wes_pkg::ColW-1:0] column_index_o,
  output logic                  last_point_o
);
  import wes_pkg::*;

  seq_state_e state_q, state_d;
  logic adv, rd_en, wr_en, load_s1;
  item_t cur_q;

  logic [ValW-1:0] v0_mem [MaxColumns];
  logic [ValW-1:0] v1_mem [MaxColumns];
  logic [MedW-1:0] m0_mem [MaxColumns];
  logic [MedW-1:0] m1_mem [MaxColumns];
  logic [ValW-1:0] od_mem [MaxColumns];

  logic [ValW-1:0] v0_c_q, v1_c_q, od_c_q, v0_e_q, v1_w_q;
  logic [MedW-1:0] m0_c_q, m1_c_q, m1_w_q, pnw_q;
  logic [ColW-1:0] col_e, col_w;

  logic signed [DiffW-1:0]   d1_q, d2_q, d3_q, d4_q;
  logic        [SumW-1:0]    s1_q, s2_q, s3_q, s4_q;
  logic signed [BaseW-1:0]   base1_q, base2_q, base3_q, base4_q, base5_q;
  logic signed [ProdW-1:0]   pr1_q, pr2_q, pr3_q, pr4_q;
  logic signed [TermW-1:0]   tx_q, ty_q;
  logic        [PartLoW-1:0] xlo_q, ylo_q;
  logic signed [PartHiW-1:0] xhi_q, yhi_q;
  logic signed [ScaledW-1:0] sx_q, sy_q;
  logic signed [TotalW-1:0]  total;
  logic signed [DeltaW-1:0]  delta_q;

  logic [5:0] vld_q;
  tag_t       tag_q [6];
  tag_t       tag_new;

  assign adv = !out_valid_o || !out_stall_i;

  always_comb begin
    state_d = state_q;
    if (adv) begin
      case (state_q)
        SeqIdle:  state_d = item_avail_i ? SeqRead : SeqIdle;
        SeqRead:  state_d = SeqWrite;
        SeqWrite: state_d = item_avail_i ? SeqRead : SeqIdle;
        default:  state_d = SeqIdle;
      endcase
    end
  end

  always_comb begin
    pop_o   = 1'b0;
    rd_en   = 1'b0;
    wr_en   = 1'b0;
    load_s1 = 1'b0;
    case (state_q)
      SeqIdle: begin
        pop_o = adv && item_avail_i;
      end
      SeqRead: begin
        rd_en = adv;
      end
      SeqWrite: begin
        pop_o   = adv && item_avail_i;
        wr_en   = adv;
        load_s1 = adv;
      end
      default: begin
        pop_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SeqIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= item_i;
    end
  end

  assign col_e = cur_q.col + 1'b1;
  assign col_w = cur_q.col - 1'b1;

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      v0_c_q <= v0_mem[cur_q.col];
      v1_c_q <= v1_mem[cur_q.col];
      m0_c_q <= m0_mem[cur_q.col];
      m1_c_q <= m1_mem[cur_q.col];
      od_c_q <= od_mem[cur_q.col];
      v0_e_q <= v0_mem[col_e];
      v1_w_q <= v1_mem[col_w];
      m1_w_q <= m1_mem[col_w];
    end
    if (wr_en) begin
      v1_mem[cur_q.col] <= v0_c_q;
      v0_mem[cur_q.col] <= cur_q.u_now;
      m1_mem[cur_q.col] <= m0_c_q;
      m0_mem[cur_q.col] <= cur_q.med;
      od_mem[cur_q.col] <= cur_q.u_before;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pnw_q <= '0;
    end else if (wr_en) begin
      pnw_q <= m1_c_q;
    end
  end

  assign tag_new.row  = cur_q.row;
  assign tag_new.col  = cur_q.col;
  assign tag_new.last = cur_q.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[4:0], load_s1 && cur_q.interior};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tag_q[0] <= tag_new;
      for (int k = 1; k < 6; k++) begin
        tag_q[k] <= tag_q[k-1];
      end

      d1_q <= $signed({v0_e_q[ValW-1], v0_e_q}) - $signed({v0_c_q[ValW-1], v0_c_q});
      d2_q <= $signed({v1_w_q[ValW-1], v1_w_q}) - $signed({v0_c_q[ValW-1], v0_c_q});
      d3_q <= $signed({cur_q.u_now[ValW-1], cur_q.u_now})
              - $signed({v0_c_q[ValW-1], v0_c_q});
      d4_q <= $signed({v1_c_q[ValW-1], v1_c_q}) - $signed({v0_c_q[ValW-1], v0_c_q});
      s1_q <= {1'b0, m1_c_q} + {1'b0, m0_c_q};
      s2_q <= {1'b0, pnw_q} + {1'b0, m1_w_q};
      s3_q <= {1'b0, m1_w_q} + {1'b0, m0_c_q};
      s4_q <= {1'b0, pnw_q} + {1'b0, m1_c_q};
      base1_q <= $signed({v0_c_q[ValW-1], v0_c_q, 1'b0})
                 - $signed({{2{od_c_q[ValW-1]}}, od_c_q});

      pr1_q <= d1_q * $signed({1'b0, s1_q});
      pr2_q <= d2_q * $signed({1'b0, s2_q});
      pr3_q <= d3_q * $signed({1'b0, s3_q});
      pr4_q <= d4_q * $signed({1'b0, s4_q});
      base2_q <= base1_q;

      tx_q <= TermW'(pr1_q) + TermW'(pr2_q);
      ty_q <= TermW'(pr3_q) + TermW'(pr4_q);
      base3_q <= base2_q;

      xlo_q <= tx_q[LoW-1:0] * coef_i.coef_x;
      ylo_q <= ty_q[LoW-1:0] * coef_i.coef_y;
      xhi_q <= $signed(tx_q[TermW-1:LoW]) * $signed({1'b0, coef_i.coef_x});
      yhi_q <= $signed(ty_q[TermW-1:LoW]) * $signed({1'b0, coef_i.coef_y});
      base4_q <= base3_q;

      sx_q <= (ScaledW'(xhi_q) <<< LoW) + $signed({{(ScaledW-PartLoW){1'b0}}, xlo_q});
      sy_q <= (ScaledW'(yhi_q) <<< LoW) + $signed({{(ScaledW-PartLoW){1'b0}}, ylo_q});
      base5_q <= base4_q;

      delta_q <= total[TotalW-1:FracShift];
    end
  end

  always_comb begin
    total = TotalW'(sx_q) + TotalW'(sy_q) + (TotalW'(1) <<< (FracShift - 1));
  end

  logic signed [BaseW-1:0] base6_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      base6_q <= base5_q;
    end
  end

  logic signed [ResW-1:0] res_out;
  assign res_out = ResW'(base6_q) + ResW'(delta_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (adv) begin
      out_valid_o <= vld_q[5];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      row_index_o    <= tag_q[5].row;
      column_index_o <= tag_q[5].col;
      last_point_o   <= tag_q[5].last;
      if (res_out > $signed(ResW'(32'sh7FFFFFFF))) begin
        u_next_o <= 32'h7FFF_FFFF;
      end else if (res_out < -$signed(ResW'(33'sh080000000))) begin
        u_next_o <= 32'h8000_0000;
      end else begin
        u_next_o <= res_out[ValW-1:0];
      end
    end
  end

endmodule

// ===== hdl/wave_equation_stencil_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wave equation stencil step
// One time step of the 2D variable-coefficient wave equation on a raster
// stream of grid points.
// ----------------------------------------------------------------------------
// Grid points enter on the input channel (in_valid_i / in_stall_o) in raster
// order, with frame_start_i set on the first point of a grid. Each interior
// point yields one item on the output channel (out_valid_o / out_stall_i)
// when the point directly below it arrives; border points yield nothing.
// Configuration registers are written through cfg_valid_i / cfg_ready_o
// while the block is idle; the user must keep to this, as the block does
// not enforce it; cfg_ready_o is always high. A front end tracks the raster
// position and classifies each point into a two-entry queue. The back end
// handles one item at a time: each item reads and then writes back its
// column of the line buffer memories, and the next item is taken during
// the write. Reset restores the register defaults and returns the position
// to the first point; the line buffers hold nothing valid until a grid is
// streamed. While out_valid_o and out_stall_i are both high the back end
// holds its state; once the queue fills, in_stall_o rises.
// ----------------------------------------------------------------------------
module wave_equation_stencil_step (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [wes_pkg::ValW-1:0] u_now_i,
  input  logic [wes_pkg::ValW-1:0] u_before_i,
  input  logic [wes_pkg::MedW-1:0] medium_req_i,
  input  logic                   frame_start_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [wes_pkg::ValW-1:0] u_next_o,
  output logic [wes_pkg::RowW-1:0] row_index_o,
  output logic [wes_pkg::ColW-1:0] column_index_o,
  output logic                   last_point_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [1:0]             cfg_index_i,
  input  logic [wes_pkg::CoefW-1:0] cfg_data_i
);
  import wes_pkg::*;

  logic [CoefW-1:0] coef_x_q, coef_y_q;
  logic [SizeW-1:0] columns_q, rows_q, cols, rows;
  coef_t coef;
  item_t front_item, queue_item;
  logic  accept, full, empty, pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_x_q  <= 24'd1175713;
      coef_y_q  <= 24'd1175713;
      columns_q <= 11'd600;
      rows_q    <= 11'd600;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CfgCoefX:       coef_x_q  <= cfg_data_i;
        CfgCoefY:       coef_y_q  <= cfg_data_i;
        CfgGridColumns: columns_q <= cfg_data_i[SizeW-1:0];
        CfgGridRows:    rows_q    <= cfg_data_i[SizeW-1:0];
        default:        coef_x_q  <= coef_x_q;
      endcase
    end
  end

  always_comb begin
    if (columns_q < 11'd3) begin
      cols = 11'd3;
    end else if (columns_q > SizeW'(MaxColumns)) begin
      cols = SizeW'(MaxColumns);
    end else begin
      cols = columns_q;
    end
    if (rows_q < 11'd3) begin
      rows = 11'd3;
    end else if (rows_q > SizeW'(MaxRows)) begin
      rows = SizeW'(MaxRows);
    end else begin
      rows = rows_q;
    end
  end

  assign coef.coef_x = coef_x_q;
  assign coef.coef_y = coef_y_q;
  assign in_stall_o  = full;
  assign accept      = in_valid_i && !full;

  wes_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cols_i        (cols),
    .rows_i        (rows),
    .accept_i      (accept),
    .u_now_i       (u_now_i),
    .u_before_i    (u_before_i),
    .medium_req_i  (medium_req_i),
    .frame_start_i (frame_start_i),
    .item_o        (front_item)
  );

  wes_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_item_i (front_item),
    .pop_i       (pop),
    .pop_item_o  (queue_item),
    .full_o      (full),
    .empty_o     (empty)
  );

  wes_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .coef_i         (coef),
    .item_i         (queue_item),
    .item_avail_i   (!empty),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .u_next_o       (u_next_o),
    .row_index_o    (row_index_o),
    .column_index_o (column_index_o),
    .last_point_o   (last_point_o)
  );

endmodule

// ===== verif/wave_equation_stencil_step_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wave equation stencil step testbench
// Streams grids of random and extreme points through the block under
// random input gaps and output stalls. A line-buffer model predicts every
// interior result, and each result is compared field by field in order.
// The grid size and coefficient registers are changed between grids.
// ----------------------------------------------------------------------------
module wave_equation_stencil_step_tb;
  import wes_pkg::*;

  localparam int WatchdogLimit = 5000;
  localparam int DrainCycles   = 16;

  typedef struct {
    logic [ValW-1:0] u_next;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic            last;
  } point_result_t;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [ValW-1:0]  u_now_i;
  logic [ValW-1:0]  u_before_i;
  logic [MedW-1:0]  medium_req_i;
  logic             frame_start_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [ValW-1:0]  u_next_o;
  logic [RowW-1:0]  row_index_o;
  logic [ColW-1:0]  column_index_o;
  logic             last_point_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [1:0]       cfg_index_i;
  logic [CoefW-1:0] cfg_data_i;

  wave_equation_stencil_step u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .u_now_i       (u_now_i),
    .u_before_i    (u_before_i),
    .medium_req_i  (medium_req_i),
    .frame_start_i (frame_start_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .u_next_o      (u_next_o),
    .row_index_o   (row_index_o),
    .column_index_o(column_index_o),
    .last_point_o  (last_point_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Predictor state.
  logic [CoefW-1:0]       coef_x_q;
  logic [CoefW-1:0]       coef_y_q;
  logic [SizeW-1:0]       columns_q;
  logic [SizeW-1:0]       rows_q;
  logic signed [ValW-1:0] value_line[2*MaxColumns];
  logic [MedW-1:0]        medium_line[2*MaxColumns];
  logic signed [ValW-1:0] old_line[MaxColumns+1];
  logic [MedW-1:0]        medium_nw;
  int unsigned            row_pos;
  int unsigned            col_pos;

  point_result_t expected_points[$];
  int            fail_count;
  int            idle_cycles;
  int            out_wait;
  bit            no_idle;
  int            random_items;
  int            value_mode;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("Mismatch in %s: got 0x%08h, expected 0x%08h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  function automatic int unsigned clamp_size(input logic [SizeW-1:0] v, input int top);
    if (v < 3) return 3;
    if (v > top) return top;
    return v;
  endfunction

  task automatic predict_point(input logic [ValW-1:0] u_in, input logic [ValW-1:0] old_in,
                               input logic [MedW-1:0] p_in, input logic fs);
    int unsigned cols;
    int unsigned rows;
    int unsigned r;
    int unsigned c;
    longint u_c, u_e, u_w, u_n, u_s, p_c, p_w, p_n, p_nw, tx, ty, delta, res;
    logic signed [127:0] wx, wy, acc;
    point_result_t pr;
    cols = clamp_size(columns_q, MaxColumns);
    rows = clamp_size(rows_q, MaxRows);
    if (fs) begin
      row_pos = 0;
      col_pos = 0;
    end
    if (col_pos >= cols) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= rows) row_pos = 0;
    r = row_pos;
    c = col_pos;
    if (r >= 2 && c >= 1 && c + 2 <= cols) begin
      u_c  = value_line[c];
      u_e  = value_line[c+1];
      u_w  = value_line[MaxColumns+c-1];
      u_n  = value_line[MaxColumns+c];
      u_s  = $signed(u_in);
      p_c  = medium_line[c];
      p_w  = medium_line[MaxColumns+c-1];
      p_n  = medium_line[MaxColumns+c];
      p_nw = medium_nw;
      tx = (u_e - u_c) * (p_n + p_c) + (u_w - u_c) * (p_nw + p_w);
      ty = (u_s - u_c) * (p_w + p_c) + (u_n - u_c) * (p_nw + p_n);
      wx = 128'(tx);
      wy = 128'(ty);
      acc = wx * $signed({104'd0, coef_x_q}) + wy * $signed({104'd0, coef_y_q})
            + (128'sd1 <<< 43);
      delta = 64'(acc >>> FracShift);
      res = 2 * u_c - longint'(old_line[c]) + delta;
      if (res > 64'sd2147483647) res = 64'sd2147483647;
      if (res < -64'sd2147483648) res = -64'sd2147483648;
      pr.u_next = res[31:0];
      pr.row    = RowW'(r - 1);
      pr.col    = ColW'(c);
      pr.last   = (r == rows - 1 && c == cols - 2);
      expected_points.push_back(pr);
    end
    medium_nw = medium_line[MaxColumns+c];
    value_line[MaxColumns+c] = value_line[c];
    value_line[c] = u_in;
    medium_line[MaxColumns+c] = medium_line[c];
    medium_line[c] = p_in;
    old_line[c] = old_in;
    col_pos = c + 1;
    if (col_pos >= cols) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= rows) row_pos = 0;
    end
  endtask

  task automatic send_point(input logic [ValW-1:0] u_in, input logic [ValW-1:0] old_in,
                            input logic [MedW-1:0] p_in, input logic fs);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    u_now_i       <= u_in;
    u_before_i    <= old_in;
    medium_req_i  <= p_in;
    frame_start_i <= fs;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    predict_point(u_in, old_in, p_in, fs);
  endtask

  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CoefW-1:0] data);
    wait_quiet();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    cfg_valid_i <= 1'b0;
    case (idx)
      CfgCoefX:       coef_x_q  = data;
      CfgCoefY:       coef_y_q  = data;
      CfgGridColumns: columns_q = data[SizeW-1:0];
      CfgGridRows:    rows_q    = data[SizeW-1:0];
      default: ;
    endcase
  endtask

  task automatic write_size(input int cols, input int rows);
    write_reg(CfgGridColumns, {13'($urandom), SizeW'(cols)});
    write_reg(CfgGridRows, {13'($urandom), SizeW'(rows)});
  endtask

  function automatic logic [ValW-1:0] draw_value();
    logic [ValW-1:0] v;
    v = $urandom;
    case (value_mode)
      0: return v;
      1: return {{8{v[23]}}, v[23:0]};
      2: return v[0] ? 32'h7fff_ffff : 32'h8000_0000;
      default: return {{4{v[27]}}, v[27:0]};
    endcase
  endfunction

  task automatic stream_grid(input int unsigned count, input bit with_start);
    for (int unsigned k = 0; k < count; k++) begin
      send_point(draw_value(), draw_value(), 24'($urandom), with_start && k == 0);
    end
  endtask

  task automatic test_reset_defaults();
    value_mode = 3;
    write_size(8, 4);
    stream_grid(8 * 4, 1'b1);
  endtask

  task automatic test_extremes();
    logic [ValW-1:0] pick[4];
    pick = '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff};
    write_size(3, 3);
    write_reg(CfgCoefX, 24'hff_ffff);
    write_reg(CfgCoefY, 24'hff_ffff);
    for (int k = 0; k < 9; k++) begin
      send_point(pick[k % 4], pick[(k + 1) % 4], (k % 2) ? 24'hff_ffff : 24'd0, k == 0);
    end
    write_reg(CfgCoefX, 24'd0);
    write_reg(CfgCoefY, 24'd0);
    for (int k = 0; k < 9; k++) begin
      send_point(pick[(k + 2) % 4], pick[k % 4], 24'hff_ffff, k == 0);
    end
    write_reg(CfgCoefX, 24'h10_0000);
    write_reg(CfgCoefY, 24'h80_0001);
    value_mode = 0;
    stream_grid(4, 1'b1);
    stream_grid(9, 1'b1);
  endtask

  task automatic test_size_clamp();
    value_mode = 1;
    write_size(0, 2047);
    stream_grid(3 * 5, 1'b1);
    write_size(2, 0);
    stream_grid(9, 1'b1);
    stream_grid(9, 1'b0);
  endtask

  task automatic test_random_grids();
    int cols;
    int rows;
    int part;
    bit started;
    bit fresh;
    started = 1'b0;
    while (random_items < 750) begin
      cols = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(3, 12);
      rows = $urandom_range(3, 10);
      write_size(cols, rows);
      write_reg(CfgCoefX, ($urandom_range(0, 5) == 0) ? 24'hff_ffff : 24'($urandom));
      write_reg(CfgCoefY, ($urandom_range(0, 5) == 0) ? 24'd0 : 24'($urandom));
      value_mode = $urandom_range(0, 3);
      no_idle = ($urandom_range(0, 3) == 0);
      fresh = 1'b0;
      if ($urandom_range(0, 5) == 0) begin
        part = $urandom_range(1, cols * rows - 1);
        stream_grid(part, 1'b1);
        random_items += part;
        fresh = 1'b1;
      end
      for (int g = $urandom_range(1, 3); g > 0; g--) begin
        stream_grid(cols * rows, !started || fresh || $urandom_range(0, 2) != 0);
        started = 1'b1;
        fresh = 1'b0;
        random_items += cols * rows;
      end
      no_idle = 1'b0;
    end
  endtask

  always @(posedge clk_i) begin
    point_result_t pr;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_points.size() == 0) begin
          report_mismatch("unexpected item", u_next_o, 32'd0);
        end else begin
          pr = expected_points.pop_front();
          if (u_next_o !== pr.u_next) report_mismatch("u_next", u_next_o, pr.u_next);
          if (row_index_o !== pr.row) begin
            report_mismatch("row_index", 32'(row_index_o), 32'(pr.row));
          end
          if (column_index_o !== pr.col) begin
            report_mismatch("column_index", 32'(column_index_o), 32'(pr.col));
          end
          if (last_point_o !== pr.last) begin
            report_mismatch("last_point", 32'(last_point_o), 32'(pr.last));
          end
        end
        out_wait = no_idle ? 0 : $urandom_range(0, 18);
      end
      if (out_wait > 0) begin
        out_stall_i <= 1'b1;
        out_wait--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    u_now_i       <= '0;
    u_before_i    <= '0;
    medium_req_i  <= '0;
    frame_start_i <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= CfgCoefX;
    cfg_data_i    <= '0;
    fail_count    = 0;
    no_idle       = 1'b0;
    random_items  = 0;
    value_mode    = 0;
    coef_x_q      = 24'd1175713;
    coef_y_q      = 24'd1175713;
    columns_q     = 11'd600;
    rows_q        = 11'd600;
    medium_nw     = '0;
    row_pos       = 0;
    col_pos       = 0;
    foreach (value_line[k]) value_line[k] = '0;
    foreach (medium_line[k]) medium_line[k] = '0;
    foreach (old_line[k]) old_line[k] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_reset_defaults();
    test_extremes();
    test_size_clamp();
    test_random_grids();
    wait_quiet();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
